>>> src/dbled_pkg.sv
package dbled_pkg;

  typedef enum logic [1:0] {
    MODE_OFF       = 2'd0,
    MODE_FADE_UP   = 2'd1,
    MODE_FADE_DOWN = 2'd2,
    MODE_STEADY    = 2'd3
  } mode_t;

  // register indexes, word address paddr[3:2]
  localparam logic [1:0] REG_MIN_LEVEL  = 2'd0;
  localparam logic [1:0] REG_MAX_LEVEL  = 2'd1;
  localparam logic [1:0] REG_FADE_STEP  = 2'd2;
  localparam logic [1:0] REG_DEBOUNCE   = 2'd3;

  localparam logic [7:0] MIN_LEVEL_RST  = 8'd14;
  localparam logic [7:0] MAX_LEVEL_RST  = 8'd241;
  localparam logic [7:0] FADE_STEP_RST  = 8'd10;
  localparam logic [7:0] DEBOUNCE_RST   = 8'd20;

  typedef struct packed {
    logic [7:0] min_level;
    logic [7:0] max_level;
    logic [7:0] fade_step_ticks;
    logic [7:0] debounce_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] brightness;
    logic [7:0] driven_level;
    logic [7:0] fade_elapsed;
    logic       last_raw;
    logic       confirmed_level;
    logic [7:0] stable_elapsed;
  } state_t;

  typedef struct packed {
    logic       press_seen;
    mode_t      mode;
    logic [7:0] led_level;
  } result_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hff) ? 8'hff : v + 8'd1;
  endfunction

endpackage

>>> src/dbled_tick.sv
// one tick of debounce, mode advance and fade, all combinational
module dbled_tick (
  input  dbled_pkg::cfg_t    cfg,
  input  dbled_pkg::state_t  st,
  input  logic               raw,
  output dbled_pkg::state_t  st_nxt,
  output dbled_pkg::result_t res
);

  logic [7:0] stable_cnt;
  logic       press;
  logic [7:0] fade_cnt;
  logic       step;

  always_comb begin
    st_nxt = st;

    // debounce
    stable_cnt = (raw != st.last_raw) ? 8'd0 : dbled_pkg::sat_inc(st.stable_elapsed);
    st_nxt.stable_elapsed = stable_cnt;
    st_nxt.last_raw = raw;
    press = 1'b0;
    if (stable_cnt > cfg.debounce_ticks && raw != st.confirmed_level) begin
      st_nxt.confirmed_level = raw;
      press = raw;
    end

    // mode advance on press
    if (press) begin
      case (st.mode)
        dbled_pkg::MODE_OFF: begin
          st_nxt.mode = dbled_pkg::MODE_FADE_UP;
          st_nxt.brightness = cfg.min_level;
        end
        dbled_pkg::MODE_FADE_UP: begin
          st_nxt.mode = dbled_pkg::MODE_FADE_DOWN;
          st_nxt.brightness = cfg.max_level;
        end
        dbled_pkg::MODE_FADE_DOWN: st_nxt.mode = dbled_pkg::MODE_STEADY;
        default: st_nxt.mode = dbled_pkg::MODE_OFF;
      endcase
    end

    // mode behavior, fade timer runs in every mode
    fade_cnt = dbled_pkg::sat_inc(st.fade_elapsed);
    step = (fade_cnt >= cfg.fade_step_ticks);
    st_nxt.fade_elapsed = fade_cnt;
    case (st_nxt.mode)
      dbled_pkg::MODE_OFF: st_nxt.driven_level = 8'd0;
      dbled_pkg::MODE_FADE_UP: begin
        if (step) begin
          st_nxt.fade_elapsed = 8'd0;
          if (st_nxt.brightness < cfg.max_level) begin
            st_nxt.brightness = st_nxt.brightness + 8'd1;
            st_nxt.driven_level = st_nxt.brightness;
          end
        end
      end
      dbled_pkg::MODE_FADE_DOWN: begin
        if (step) begin
          st_nxt.fade_elapsed = 8'd0;
          if (st_nxt.brightness > cfg.min_level) begin
            st_nxt.brightness = st_nxt.brightness - 8'd1;
            st_nxt.driven_level = st_nxt.brightness;
          end
        end
      end
      default: st_nxt.driven_level = cfg.max_level;
    endcase

    res.press_seen = press;
    res.mode = st_nxt.mode;
    res.led_level = st_nxt.driven_level;
  end

endmodule

>>> src/debounced_button_led_fade_modes.sv
// debounced push button driving a four-mode led fade controller
//
// in_*  : one transfer per millisecond tick, in_tdata[0] is the raw button
//         sample (1 = pressed)
// out_* : exactly one transfer per tick: led duty, mode and a press flag
// cfg_* : apb register port, min level, max level, fade step time and
//         debounce time at byte addresses 0, 4, 8, 12; pready is tied high
//
// a tick is latched in an input register, then processed combinationally by
// the tick logic, which updates the controller state and writes the result
// into a two-entry output register (main plus skid); out_tvalid comes from
// that output register, so each result passes the input register and then
// the output register before it is offered, and one tick is taken every
// cycle while the receiver keeps up
// when the receiver stalls the skid entry fills, in_tready drops and the
// pending tick waits in the input register; no tick is lost or repeated
// reset (rst_n low, synchronous) returns all state to off with zero
// brightness and reloads the register defaults; it needs no clearing pass
module debounced_button_led_fade_modes (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [0] button_raw, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] led_level, [9:8] mode, [10] press_seen, [15:11] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  dbled_pkg::cfg_t    cfg_r;
  dbled_pkg::state_t  st_r, st_nxt;
  dbled_pkg::result_t res;

  // input register
  logic in_valid_r;
  logic raw_r;

  // output register plus skid entry
  logic               out_valid_r;
  dbled_pkg::result_t out_r;
  logic               skid_valid_r;
  dbled_pkg::result_t skid_r;

  logic proc;
  logic pop;
  logic cfg_wr;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_level       <= dbled_pkg::MIN_LEVEL_RST;
      cfg_r.max_level       <= dbled_pkg::MAX_LEVEL_RST;
      cfg_r.fade_step_ticks <= dbled_pkg::FADE_STEP_RST;
      cfg_r.debounce_ticks  <= dbled_pkg::DEBOUNCE_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        dbled_pkg::REG_MIN_LEVEL: cfg_r.min_level       <= cfg_pwdata[7:0];
        dbled_pkg::REG_MAX_LEVEL: cfg_r.max_level       <= cfg_pwdata[7:0];
        dbled_pkg::REG_FADE_STEP: cfg_r.fade_step_ticks <= cfg_pwdata[7:0];
        default:                  cfg_r.debounce_ticks  <= cfg_pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      dbled_pkg::REG_MIN_LEVEL: cfg_prdata = {24'd0, cfg_r.min_level};
      dbled_pkg::REG_MAX_LEVEL: cfg_prdata = {24'd0, cfg_r.max_level};
      dbled_pkg::REG_FADE_STEP: cfg_prdata = {24'd0, cfg_r.fade_step_ticks};
      default:                  cfg_prdata = {24'd0, cfg_r.debounce_ticks};
    endcase
  end

  // ---------------- handshake control ----------------
  // a latched tick is processed whenever the skid entry is free
  assign proc      = in_valid_r & ~skid_valid_r;
  assign in_tready = ~in_valid_r | ~skid_valid_r;
  assign pop       = out_valid_r & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      raw_r <= in_tdata[0];
    end
  end

  // ---------------- tick processing ----------------
  dbled_tick u_tick (
    .cfg    (cfg_r),
    .st     (st_r),
    .raw    (raw_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode            <= dbled_pkg::MODE_OFF;
      st_r.brightness      <= 8'd0;
      st_r.driven_level    <= 8'd0;
      st_r.fade_elapsed    <= 8'd0;
      st_r.last_raw        <= 1'b0;
      st_r.confirmed_level <= 1'b0;
      st_r.stable_elapsed  <= 8'd0;
    end else if (proc) begin
      st_r <= st_nxt;
    end
  end

  // ---------------- output register and skid ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || pop) begin
        // main entry frees up: take the skid entry first, else the new result
        out_valid_r  <= skid_valid_r | proc;
        skid_valid_r <= 1'b0;
      end else if (proc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (out_valid_r && !pop && proc) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_r.press_seen, out_r.mode, out_r.led_level};

endmodule
